// ===== sv/mmdcs_pkg.sv =====
package mmdcs_pkg;

   // store geometry
   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = ADDR_W + 1;

   // field widths
   localparam int COORD_W = 14;
   localparam int GW_W    = 12;
   localparam int STEP_W  = 8;
   localparam int OP_W    = 2;
   localparam int CSR_W   = 2;
   localparam int CTR_W   = 15;
   localparam int DX_W    = 16;
   localparam int SQ_W    = 29;
   localparam int D2_W    = 30;
   localparam int RAD_W   = 19;

   // sample index must reach count - 1 + largest stride
   localparam int IDX_W = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;

   // integer root unit
   localparam int ROOT_N_W   = 2 * RAD_W;
   localparam int REM_W      = RAD_W + 3;
   localparam int ROOT_CNT_W = $clog2(RAD_W + 1);

   localparam logic [STEP_W-1:0] CONTOUR_STEP_RST = STEP_W'(20);
   localparam logic [STEP_W-1:0] GRID_STEP_RST    = STEP_W'(5);

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_SEARCH = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_CONTOUR_STEP = 2'd0,
      CSR_GRID_STEP    = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_WAIT_ROOT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              load;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              rd_first;
      logic              rd_last;
      logic              update;
      logic              next_col;
      logic              next_row;
      logic [STEP_W-1:0] grid_step;
      logic              root_start;
      logic              emit;
      logic              dropped;
   } cmd_type;

   typedef struct packed {
      logic min_done;
      logic root_done;
   } status_type;

endpackage

// ===== sv/mmdcs_isqrt.sv =====
module mmdcs_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mmdcs_pkg::ROOT_N_W-1:0]  operand,
   output logic                            done,
   output logic [mmdcs_pkg::RAD_W-1:0]     root
);
   import mmdcs_pkg::*;

   logic [ROOT_N_W-1:0]   n_ff, n_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [RAD_W-1:0]      root_ff, root_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;

   // one result bit per cycle, two operand bits shifted in
   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], n_ff[ROOT_N_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = ROOT_CNT_W'(RAD_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         n_in = {n_ff[ROOT_N_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RAD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RAD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - ROOT_CNT_W'(1);
         if (cnt_ff == ROOT_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== sv/mmdcs_dp.sv =====
module mmdcs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  mmdcs_pkg::cmd_type                  cmd,
   output mmdcs_pkg::status_type               status,
   input  logic signed [mmdcs_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [mmdcs_pkg::COORD_W-1:0] req_pos_y,
   input  logic [mmdcs_pkg::GW_W-1:0]          req_grid_width,
   output logic                                rsp_strobe,
   output logic signed [mmdcs_pkg::CTR_W-1:0]  rsp_center_x,
   output logic signed [mmdcs_pkg::CTR_W-1:0]  rsp_center_y,
   output logic [mmdcs_pkg::RAD_W-1:0]         rsp_radius_q4,
   output logic                                rsp_points_dropped
);
   import mmdcs_pkg::*;

   // point store, x and y side by side
   logic [2*COORD_W-1:0] mem [MAX_POINTS];
   logic [2*COORD_W-1:0] mem_q_ff;

   logic [CTR_W-1:0] sx_ff, gx_ff, gy_ff, bx_ff, by_ff;
   logic [CTR_W-1:0] px_ext, py_ext, half_ext;
   logic [D2_W-1:0]  best_ff, mn_ff, d2;
   logic [DX_W-1:0]  dx_ff, dy_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic signed [2*DX_W-1:0] sqx_full, sqy_full;
   logic [COORD_W-1:0] mx, my;

   logic v0_ff, f0_ff, l0_ff;
   logic v1_ff, f1_ff, l1_ff;
   logic v2_ff, f2_ff, l2_ff;
   logic done_ff;

   logic             strobe_ff;
   logic [CTR_W-1:0] out_x_ff, out_y_ff;
   logic [RAD_W-1:0] out_r_ff;
   logic             out_d_ff;

   logic             root_done;
   logic [RAD_W-1:0] root;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {req_pos_x, req_pos_y};
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[cmd.rd_addr];
      end
   end

   assign px_ext   = {req_pos_x[COORD_W-1], req_pos_x};
   assign py_ext   = {req_pos_y[COORD_W-1], req_pos_y};
   assign half_ext = CTR_W'(req_grid_width[GW_W-1:1]);

   assign mx = mem_q_ff[2*COORD_W-1:COORD_W];
   assign my = mem_q_ff[COORD_W-1:0];

   assign sqx_full = $signed(dx_ff) * $signed(dx_ff);
   assign sqy_full = $signed(dy_ff) * $signed(dy_ff);
   assign d2       = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // grid position and best candidate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff   <= px_ext - half_ext;
         gx_ff   <= px_ext - half_ext;
         gy_ff   <= py_ext - half_ext;
         bx_ff   <= px_ext;
         by_ff   <= py_ext;
         best_ff <= '0;
      end else begin
         if (cmd.update && (mn_ff > best_ff)) begin
            best_ff <= mn_ff;
            bx_ff   <= gx_ff;
            by_ff   <= gy_ff;
         end
         if (cmd.next_col) begin
            gx_ff <= gx_ff + CTR_W'(cmd.grid_step);
         end else if (cmd.next_row) begin
            gx_ff <= sx_ff;
            gy_ff <= gy_ff + CTR_W'(cmd.grid_step);
         end
      end
   end

   // distance pipeline: read, difference, square, running minimum
   always_ff @(posedge clock) begin
      dx_ff  <= {gx_ff[CTR_W-1], gx_ff} - {{(DX_W-COORD_W){mx[COORD_W-1]}}, mx};
      dy_ff  <= {gy_ff[CTR_W-1], gy_ff} - {{(DX_W-COORD_W){my[COORD_W-1]}}, my};
      sqx_ff <= sqx_full[SQ_W-1:0];
      sqy_ff <= sqy_full[SQ_W-1:0];
      f0_ff  <= cmd.rd_first;
      l0_ff  <= cmd.rd_last;
      f1_ff  <= f0_ff;
      l1_ff  <= l0_ff;
      f2_ff  <= f1_ff;
      l2_ff  <= l1_ff;
      if (v2_ff) begin
         if (f2_ff || (d2 < mn_ff)) begin
            mn_ff <= d2;
         end
      end
      if (reset) begin
         v0_ff   <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff   <= cmd.rd_en;
         v1_ff   <= v0_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff & l2_ff;
      end
   end

   mmdcs_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.root_start),
      .operand ({best_ff, 8'd0}),
      .done    (root_done),
      .root    (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_x_ff <= bx_ff;
         out_y_ff <= by_ff;
         out_r_ff <= root;
         out_d_ff <= cmd.dropped;
      end
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign status.min_done  = done_ff;
   assign status.root_done = root_done;

   assign rsp_strobe         = strobe_ff;
   assign rsp_center_x       = out_x_ff;
   assign rsp_center_y       = out_y_ff;
   assign rsp_radius_q4      = out_r_ff;
   assign rsp_points_dropped = out_d_ff;

endmodule

// ===== sv/mmdcs_ctrl.sv =====
module mmdcs_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mmdcs_pkg::OP_W-1:0]        req_opcode,
   input  logic [mmdcs_pkg::GW_W-1:0]        req_grid_width,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mmdcs_pkg::CSR_W-1:0]       csr_index,
   input  logic [mmdcs_pkg::STEP_W-1:0]      csr_wdata,
   output mmdcs_pkg::cmd_type                cmd,
   input  mmdcs_pkg::status_type             status
);
   import mmdcs_pkg::*;

   state_type state_ff, state_in;

   logic [STEP_W-1:0] contour_step_ff, grid_step_ff;
   logic [STEP_W-1:0] cs, gs;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  idx_ff, idx_in, idx_next;
   logic [GW_W-1:0]   gw_ff, gw_in;
   logic [GW_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [GW_W:0]     w_next, h_next;

   assign cs = (contour_step_ff == '0) ? STEP_W'(1) : contour_step_ff;
   assign gs = (grid_step_ff == '0) ? STEP_W'(1) : grid_step_ff;

   assign idx_next = idx_ff + IDX_W'(cs);
   assign w_next   = {1'b0, w_ff} + (GW_W + 1)'(gs);
   assign h_next   = {1'b0, h_ff} + (GW_W + 1)'(gs);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      gw_in    = gw_ff;
      w_in     = w_ff;
      h_in     = h_ff;

      cmd            = '0;
      cmd.wr_addr    = count_ff[ADDR_W-1:0];
      cmd.rd_addr    = idx_ff[ADDR_W-1:0];
      cmd.grid_step  = gs;
      cmd.dropped    = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(MAX_POINTS)) begin
                        cmd.wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     cmd.load = 1'b1;
                     gw_in    = req_grid_width;
                     idx_in   = '0;
                     w_in     = '0;
                     h_in     = '0;
                     if ((count_ff == '0) || (req_grid_width == '0)) begin
                        state_in = ST_ROOT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one sampled point per cycle into the distance pipeline
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (idx_ff == '0);
            cmd.rd_last  = (idx_next >= IDX_W'(count_ff));
            if (cmd.rd_last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_DRAIN: begin
            if (status.min_done) begin
               cmd.update = 1'b1;
               idx_in     = '0;
               if (w_next < {1'b0, gw_ff}) begin
                  cmd.next_col = 1'b1;
                  w_in         = w_next[GW_W-1:0];
                  state_in     = ST_SCAN;
               end else if (h_next < {1'b0, gw_ff}) begin
                  cmd.next_row = 1'b1;
                  w_in         = '0;
                  h_in         = h_next[GW_W-1:0];
                  state_in     = ST_SCAN;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            cmd.root_start = 1'b1;
            state_in       = ST_WAIT_ROOT;
         end
         ST_WAIT_ROOT: begin
            if (status.root_done) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         idx_ff          <= '0;
         gw_ff           <= '0;
         w_ff            <= '0;
         h_ff            <= '0;
         contour_step_ff <= CONTOUR_STEP_RST;
         grid_step_ff    <= GRID_STEP_RST;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
         gw_ff    <= gw_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CONTOUR_STEP: contour_step_ff <= csr_wdata;
               CSR_GRID_STEP:    grid_step_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

endmodule

// ===== sv/max_min_distance_center_search.sv =====
// max_min_distance_center_search
// Input channel: an item is taken when start is high and busy is low. Opcode
// append stores (req_pos_x, req_pos_y) and clear empties the store; both
// leave busy low. Opcode search raises busy until its result.
// Result channel: rsp_strobe is high for one cycle with center, radius (Q.4)
// and the dropped-points flag; the receiver cannot stall, so the result is
// simply shown for that cycle while a new item may already be taken.
// The distance pipeline takes one sampled contour point per cycle while a grid
// point is scanned and is drained after each grid point; the radius comes from
// a bit-serial root unit.
// An empty store or a zero grid width skips straight to the root unit.
// Configuration port: csr_index 0 is contour_step, 1 is grid_step; always
// ready. The user writes it only while busy is low; the block does not check.
// Reset (synchronous): store empty, flag clear, steps back to 20 and 5.
module max_min_distance_center_search (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mmdcs_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [mmdcs_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [mmdcs_pkg::COORD_W-1:0] req_pos_y,
   input  logic [mmdcs_pkg::GW_W-1:0]           req_grid_width,
   output logic                                 rsp_strobe,
   output logic signed [mmdcs_pkg::CTR_W-1:0]   rsp_center_x,
   output logic signed [mmdcs_pkg::CTR_W-1:0]   rsp_center_y,
   output logic [mmdcs_pkg::RAD_W-1:0]          rsp_radius_q4,
   output logic                                 rsp_points_dropped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mmdcs_pkg::CSR_W-1:0]          csr_index,
   input  logic [mmdcs_pkg::STEP_W-1:0]         csr_wdata
);
   import mmdcs_pkg::*;

   cmd_type    cmd;
   status_type status;

   mmdcs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_grid_width (req_grid_width),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status)
   );

   mmdcs_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_grid_width     (req_grid_width),
      .rsp_strobe         (rsp_strobe),
      .rsp_center_x       (rsp_center_x),
      .rsp_center_y       (rsp_center_y),
      .rsp_radius_q4      (rsp_radius_q4),
      .rsp_points_dropped (rsp_points_dropped)
   );

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a search in progress");

   a_search_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == OP_SEARCH)) |=> busy)
      else $error("search item did not raise busy");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != OP_SEARCH)) |=> (!busy && !rsp_strobe))
      else $error("append or clear item disturbed the block");
`endif

endmodule
